// File: rtl/spc_pkg.sv
// ----------------------------------------------------------------------------
// spc_pkg: shared types and constants for the shape pair collision test
// Shape kind codes, pair classes, the stage tag and the multiplier slot map.
// ----------------------------------------------------------------------------
package spc_pkg;

    // one-hot shape kinds
    localparam logic [3:0] KIND_PT   = 4'd1;
    localparam logic [3:0] KIND_RECT = 4'd2;
    localparam logic [3:0] KIND_CIRC = 4'd4;
    localparam logic [3:0] KIND_LINE = 4'd8;

    // pair class after kind ordering, lower kind first
    typedef enum logic [3:0] {
        PR_NONE,
        PR_PP,
        PR_PR,
        PR_PC,
        PR_PL,
        PR_RR,
        PR_RC,
        PR_RL,
        PR_CC,
        PR_CL,
        PR_LL
    } t_pair;

    // control that travels with each request down the pipeline
    typedef struct packed {
        t_pair pair;
        logic  kill;   // negative radius or circle clearly outside the rectangle
        logic  hit;    // decision made so far
        logic  need;   // final wide compare decides the hit
    } t_tag;

    // multiplier slots
    localparam int NUM_SLOT  = 11;
    localparam int SL_DOT_X  = 0;
    localparam int SL_DOT_Y  = 1;
    localparam int SL_LEN_X  = 2;
    localparam int SL_LEN_Y  = 3;
    localparam int SL_F_X    = 4;
    localparam int SL_F_Y    = 5;
    localparam int SL_G_X    = 6;
    localparam int SL_G_Y    = 7;
    localparam int SL_CR_A   = 8;
    localparam int SL_CR_B   = 9;
    localparam int SL_RAD    = 10;

endpackage

// File: rtl/spc_front.sv
// ----------------------------------------------------------------------------
// spc_front: ordering, differences and multiplier operand selection
// Stage 1 orders the shapes by kind, classifies the pair, settles the pure
// compare cases and forms differences. Stage 2 prepares the rectangle-circle
// distances and routes operands to the multiplier slots.
// ----------------------------------------------------------------------------
module spc_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [3:0]                    i_left_kind,
    input  logic signed [COORD_BITS-1:0]  i_left_a,
    input  logic signed [COORD_BITS-1:0]  i_left_b,
    input  logic signed [COORD_BITS-1:0]  i_left_c,
    input  logic signed [COORD_BITS-1:0]  i_left_d,
    input  logic [3:0]                    i_right_kind,
    input  logic signed [COORD_BITS-1:0]  i_right_a,
    input  logic signed [COORD_BITS-1:0]  i_right_b,
    input  logic signed [COORD_BITS-1:0]  i_right_c,
    input  logic signed [COORD_BITS-1:0]  i_right_d,
    output logic                          o_valid,
    output spc_pkg::t_tag                 o_tag,
    output logic signed [COORD_BITS+1:0]  o_ma [spc_pkg::NUM_SLOT],
    output logic signed [COORD_BITS+1:0]  o_mb [spc_pkg::NUM_SLOT]
);
    import spc_pkg::*;

    localparam int C = COORD_BITS;
    localparam int D = COORD_BITS + 2;

    logic                swap;
    logic [3:0]          pk, qk;
    logic signed [C-1:0] pa, pb, pc, pd, qa, qb, qc, qd;
    t_pair               pair;
    logic                simple_hit, kill;
    t_tag                n1_tag;

    logic                r1_v;
    t_tag                r1_tag;
    logic signed [D-1:0] r1_e1, r1_e2, r1_e3, r1_e4, r1_g1, r1_g2, r1_da, r1_db;
    logic signed [D-1:0] r1_rx, r1_ry, r1_rad2, r1_rcs, r1_pc, r1_qc;

    logic signed [D-1:0] ax, ay, ex, ey;
    logic signed [D:0]   limx, limy;
    logic                rc_out, rc_in;
    t_tag                n2_tag;
    logic signed [D-1:0] n_ma [NUM_SLOT];
    logic signed [D-1:0] n_mb [NUM_SLOT];

    // order the shapes, lower kind first, left first on a tie
    always_comb begin
        swap = i_left_kind > i_right_kind;
        pk = swap ? i_right_kind : i_left_kind;
        qk = swap ? i_left_kind  : i_right_kind;
        pa = swap ? i_right_a : i_left_a;
        pb = swap ? i_right_b : i_left_b;
        pc = swap ? i_right_c : i_left_c;
        pd = swap ? i_right_d : i_left_d;
        qa = swap ? i_left_a : i_right_a;
        qb = swap ? i_left_b : i_right_b;
        qc = swap ? i_left_c : i_right_c;
        qd = swap ? i_left_d : i_right_d;
    end

    // classify the pair
    always_comb begin
        case ({pk, qk})
            {KIND_PT,   KIND_PT}:   pair = PR_PP;
            {KIND_PT,   KIND_RECT}: pair = PR_PR;
            {KIND_PT,   KIND_CIRC}: pair = PR_PC;
            {KIND_PT,   KIND_LINE}: pair = PR_PL;
            {KIND_RECT, KIND_RECT}: pair = PR_RR;
            {KIND_RECT, KIND_CIRC}: pair = PR_RC;
            {KIND_RECT, KIND_LINE}: pair = PR_RL;
            {KIND_CIRC, KIND_CIRC}: pair = PR_CC;
            {KIND_CIRC, KIND_LINE}: pair = PR_CL;
            {KIND_LINE, KIND_LINE}: pair = PR_LL;
            default:                pair = PR_NONE;
        endcase
    end

    // settle the pairs that need only compares
    always_comb begin
        case (pair)
            PR_PP:   simple_hit = (pa == qa) && (pb == qb);
            PR_PR:   simple_hit = (pa >= qa) && (pa <= qc) && (pb >= qb) && (pb <= qd);
            PR_RR:   simple_hit = (pa <= qc) && (pc >= qa) && (pb <= qd) && (pd >= qb);
            PR_RL:   simple_hit = ((qa >= pa) && (qa <= pc) && (qb >= pb) && (qb <= pd)) ||
                                  ((qc >= pa) && (qc <= pc) && (qd >= pb) && (qd <= pd));
            default: simple_hit = 1'b0;
        endcase
    end

    // flag a negative radius
    always_comb begin
        case (pair)
            PR_PC, PR_RC: kill = qc[C-1];
            PR_CC:        kill = pc[C-1] || qc[C-1];
            PR_CL:        kill = pc[C-1];
            default:      kill = 1'b0;
        endcase
        n1_tag = '{pair: pair, kill: kill, hit: simple_hit, need: 1'b0};
    end

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start;
        end
        r1_tag  <= n1_tag;
        r1_e1   <= D'(pc) - D'(pa);
        r1_e2   <= D'(pd) - D'(pb);
        r1_e3   <= D'(qc) - D'(qa);
        r1_e4   <= D'(qd) - D'(qb);
        r1_g1   <= D'(pa) - D'(qc);
        r1_g2   <= D'(pb) - D'(qd);
        r1_da   <= D'(pa) - D'(qa);
        r1_db   <= D'(pb) - D'(qb);
        r1_rx   <= (D'(qa) <<< 1) - D'(pa) - D'(pc);
        r1_ry   <= (D'(qb) <<< 1) - D'(pb) - D'(pd);
        r1_rad2 <= D'(qc) <<< 1;
        r1_rcs  <= D'(pc) + D'(qc);
        r1_pc   <= D'(pc);
        r1_qc   <= D'(qc);
    end

    // rectangle-circle: distance from the rectangle centre in doubled units
    always_comb begin
        ax     = r1_rx[D-1] ? -r1_rx : r1_rx;
        ay     = r1_ry[D-1] ? -r1_ry : r1_ry;
        limx   = (D+1)'(r1_e1) + (D+1)'(r1_rad2);
        limy   = (D+1)'(r1_e2) + (D+1)'(r1_rad2);
        rc_out = ((D+1)'(ax) > limx) || ((D+1)'(ay) > limy);
        rc_in  = (ax <= r1_e1) || (ay <= r1_e2);
        ex     = ax - r1_e1;
        ey     = ay - r1_e2;
        n2_tag = r1_tag;
        if (r1_tag.pair == PR_RC) begin
            n2_tag.hit  = !r1_tag.kill && !rc_out && rc_in;
            n2_tag.kill = r1_tag.kill || rc_out;
        end
    end

    // route operands to the multiplier slots
    always_comb begin
        for (int i = 0; i < NUM_SLOT; i++) begin
            n_ma[i] = '0;
            n_mb[i] = '0;
        end
        case (r1_tag.pair)
            PR_PC, PR_CC: begin
                n_ma[SL_DOT_X] = r1_da;  n_mb[SL_DOT_X] = r1_da;
                n_ma[SL_DOT_Y] = r1_db;  n_mb[SL_DOT_Y] = r1_db;
                n_ma[SL_RAD]   = (r1_tag.pair == PR_PC) ? r1_qc : r1_rcs;
                n_mb[SL_RAD]   = (r1_tag.pair == PR_PC) ? r1_qc : r1_rcs;
            end
            PR_RC: begin
                n_ma[SL_DOT_X] = ex;      n_mb[SL_DOT_X] = ex;
                n_ma[SL_DOT_Y] = ey;      n_mb[SL_DOT_Y] = ey;
                n_ma[SL_RAD]   = r1_rad2; n_mb[SL_RAD]   = r1_rad2;
            end
            PR_CL: begin
                n_ma[SL_DOT_X] = r1_da;  n_mb[SL_DOT_X] = r1_e3;
                n_ma[SL_DOT_Y] = r1_db;  n_mb[SL_DOT_Y] = r1_e4;
                n_ma[SL_LEN_X] = r1_e3;  n_mb[SL_LEN_X] = r1_e3;
                n_ma[SL_LEN_Y] = r1_e4;  n_mb[SL_LEN_Y] = r1_e4;
                n_ma[SL_F_X]   = r1_da;  n_mb[SL_F_X]   = r1_da;
                n_ma[SL_F_Y]   = r1_db;  n_mb[SL_F_Y]   = r1_db;
                n_ma[SL_G_X]   = r1_g1;  n_mb[SL_G_X]   = r1_g1;
                n_ma[SL_G_Y]   = r1_g2;  n_mb[SL_G_Y]   = r1_g2;
                n_ma[SL_CR_A]  = r1_da;  n_mb[SL_CR_A]  = r1_e4;
                n_ma[SL_CR_B]  = r1_db;  n_mb[SL_CR_B]  = r1_e3;
                n_ma[SL_RAD]   = r1_pc;  n_mb[SL_RAD]   = r1_pc;
            end
            PR_LL: begin
                // det from the dot slots, numerators from the len and f slots
                n_ma[SL_DOT_X] = r1_e1;  n_mb[SL_DOT_X] = r1_e4;
                n_ma[SL_DOT_Y] = r1_e2;  n_mb[SL_DOT_Y] = r1_e3;
                n_ma[SL_LEN_X] = r1_da;  n_mb[SL_LEN_X] = r1_e4;
                n_ma[SL_LEN_Y] = r1_db;  n_mb[SL_LEN_Y] = r1_e3;
                n_ma[SL_F_X]   = r1_e1;  n_mb[SL_F_X]   = r1_db;
                n_ma[SL_F_Y]   = r1_e2;  n_mb[SL_F_Y]   = r1_da;
            end
            default: begin
            end
        endcase
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r1_v;
        end
        o_tag <= n2_tag;
        for (int i = 0; i < NUM_SLOT; i++) begin
            o_ma[i] <= n_ma[i];
            o_mb[i] <= n_mb[i];
        end
    end

endmodule

// File: rtl/spc_mult.sv
// ----------------------------------------------------------------------------
// spc_mult: product stage and first-level decisions
// Stage 3 forms all slot products. Stage 4 sums them and settles every test
// but the interior circle-segment case, which goes on to the wide compare.
// ----------------------------------------------------------------------------
module spc_mult #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  spc_pkg::t_tag                  i_tag,
    input  logic signed [COORD_BITS+1:0]   i_ma [spc_pkg::NUM_SLOT],
    input  logic signed [COORD_BITS+1:0]   i_mb [spc_pkg::NUM_SLOT],
    output logic                           o_valid,
    output spc_pkg::t_tag                  o_tag,
    output logic signed [2*COORD_BITS+4:0] o_cr,
    output logic signed [2*COORD_BITS+4:0] o_len,
    output logic signed [2*COORD_BITS+4:0] o_r2
);
    import spc_pkg::*;

    localparam int D = COORD_BITS + 2;
    localparam int P = 2 * D;
    localparam int W = P + 1;

    logic                r3_v;
    t_tag                r3_tag;
    logic signed [P-1:0] r3_p [NUM_SLOT];

    logic signed [W-1:0] s_dot, s_len, s_f, s_g, s_cr, s_det, s_n1, s_n2, s_r2;
    logic                c_sq, dot_le0, len_le, f_ok, g_ok, ll_hit;
    t_tag                n4_tag;

    // stage 3: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= i_valid;
        end
        r3_tag <= i_tag;
        for (int i = 0; i < NUM_SLOT; i++) begin
            r3_p[i] <= P'(i_ma[i]) * P'(i_mb[i]);
        end
    end

    // sums of products
    always_comb begin
        s_dot = W'(r3_p[SL_DOT_X]) + W'(r3_p[SL_DOT_Y]);
        s_len = W'(r3_p[SL_LEN_X]) + W'(r3_p[SL_LEN_Y]);
        s_f   = W'(r3_p[SL_F_X])   + W'(r3_p[SL_F_Y]);
        s_g   = W'(r3_p[SL_G_X])   + W'(r3_p[SL_G_Y]);
        s_cr  = W'(r3_p[SL_CR_A])  - W'(r3_p[SL_CR_B]);
        s_det = W'(r3_p[SL_DOT_X]) - W'(r3_p[SL_DOT_Y]);
        s_n1  = W'(r3_p[SL_LEN_Y]) - W'(r3_p[SL_LEN_X]);
        s_n2  = W'(r3_p[SL_F_Y])   - W'(r3_p[SL_F_X]);
        s_r2  = W'(r3_p[SL_RAD]);
    end

    // decisions on the sums
    always_comb begin
        c_sq    = s_dot <= s_r2;
        dot_le0 = s_dot[W-1] || (s_dot == '0);
        len_le  = s_len <= s_dot;
        f_ok    = s_f <= s_r2;
        g_ok    = s_g <= s_r2;
        // crossing point must lie on both segments, ends included
        if (s_det == '0) begin
            ll_hit = 1'b0;
        end else if (!s_det[W-1]) begin
            ll_hit = !s_n1[W-1] && (s_n1 <= s_det) && !s_n2[W-1] && (s_n2 <= s_det);
        end else begin
            ll_hit = (s_n1[W-1] || (s_n1 == '0)) && (s_n1 >= s_det) &&
                     (s_n2[W-1] || (s_n2 == '0)) && (s_n2 >= s_det);
        end
        n4_tag      = r3_tag;
        n4_tag.need = 1'b0;
        case (r3_tag.pair)
            PR_PC, PR_CC: n4_tag.hit = !r3_tag.kill && c_sq;
            PR_RC:        n4_tag.hit = r3_tag.hit || (!r3_tag.kill && c_sq);
            PR_CL: begin
                n4_tag.hit  = !r3_tag.kill && (dot_le0 ? f_ok : (len_le && g_ok));
                n4_tag.need = !r3_tag.kill && !dot_le0 && !len_le;
            end
            PR_LL:        n4_tag.hit = ll_hit;
            default:      n4_tag.hit = r3_tag.hit;
        endcase
    end

    // stage 4 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r3_v;
        end
        o_tag <= n4_tag;
        o_cr  <= s_cr;
        o_len <= s_len;
        o_r2  <= s_r2;
    end

endmodule

// File: rtl/spc_wide.sv
// ----------------------------------------------------------------------------
// spc_wide: split wide compare of cross squared against radius squared times
// length squared, and the result register
// Stage 5 takes the magnitude, stage 6 forms half-width partial products,
// stage 7 adds them up, stage 8 compares and drives the result.
// ----------------------------------------------------------------------------
module spc_wide #(
    parameter int COORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  spc_pkg::t_tag                  i_tag,
    input  logic signed [2*COORD_BITS+4:0] i_cr,
    input  logic signed [2*COORD_BITS+4:0] i_len,
    input  logic signed [2*COORD_BITS+4:0] i_r2,
    output logic                           o_valid,
    output logic                           o_hit,
    output logic                           o_pair_valid
);
    import spc_pkg::*;

    localparam int W  = 2 * COORD_BITS + 5;
    localparam int H  = (W + 1) / 2;
    localparam int HW = W - H;
    localparam int X  = 2 * W;

    logic           r5_v, r6_v, r7_v;
    t_tag           r5_tag, r6_tag, r7_tag;
    logic [W-1:0]   r5_cr, r5_len, r5_r2;
    logic [2*HW-1:0] r6_chh, r6_rhh;
    logic [W-1:0]   r6_chl, r6_rhl, r6_rlh;
    logic [2*H-1:0] r6_cll, r6_rll;
    logic [X-1:0]   r7_crsq, r7_bound;

    // stage 5: magnitude of the cross product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= i_valid;
        end
        r5_tag <= i_tag;
        r5_cr  <= i_cr[W-1] ? $unsigned(-i_cr) : $unsigned(i_cr);
        r5_len <= $unsigned(i_len);
        r5_r2  <= $unsigned(i_r2);
    end

    // stage 6: half-width partial products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else begin
            r6_v <= r5_v;
        end
        r6_tag <= r5_tag;
        r6_chh <= r5_cr[W-1:H] * r5_cr[W-1:H];
        r6_chl <= r5_cr[W-1:H] * r5_cr[H-1:0];
        r6_cll <= r5_cr[H-1:0] * r5_cr[H-1:0];
        r6_rhh <= r5_r2[W-1:H] * r5_len[W-1:H];
        r6_rhl <= r5_r2[W-1:H] * r5_len[H-1:0];
        r6_rlh <= r5_r2[H-1:0] * r5_len[W-1:H];
        r6_rll <= r5_r2[H-1:0] * r5_len[H-1:0];
    end

    // stage 7: add the partial products up
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else begin
            r7_v <= r6_v;
        end
        r7_tag   <= r6_tag;
        r7_crsq  <= (X'(r6_chh) << (2 * H)) + (X'(r6_chl) << (H + 1)) + X'(r6_cll);
        r7_bound <= (X'(r6_rhh) << (2 * H)) + ((X'(r6_rhl) + X'(r6_rlh)) << H) + X'(r6_rll);
    end

    // stage 8: compare and drive the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r7_v;
        end
        o_hit        <= r7_tag.need ? (r7_crsq <= r7_bound) : r7_tag.hit;
        o_pair_valid <= r7_tag.pair != PR_NONE;
    end

    a_need_cl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r7_v && r7_tag.need) |-> (r7_tag.pair == PR_CL))
        else $error("wide compare requested for a pair other than circle-segment");

    a_bad_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r7_v && (r7_tag.pair == PR_NONE)) |=> (o_valid && !o_hit && !o_pair_valid))
        else $error("unsupported pair reported a hit");

endmodule

// File: rtl/shape_pair_collision_test.sv
// ----------------------------------------------------------------------------
// shape_pair_collision_test: exact overlap test for one pair of 2D shapes
// Points, rectangles, circles and segments in any combination, integer only.
// ----------------------------------------------------------------------------
// Pipeline: a request accepted on start passes stages 1 to 8 in order; o_valid
//   and the result are driven by the stage 8 register.
// Throughput: one request per cycle; busy stays low, the eight register
//   stages (the last four a half-width split multiply and compare for the
//   segment distance) all advance every cycle.
// Reset: synchronous active low; clears the stage valid bits only.
// The receiver cannot stall: each result is on the ports for one cycle.
module shape_pair_collision_test #(
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [3:0]                   i_left_kind,
    input  logic signed [COORD_BITS-1:0] i_left_a,
    input  logic signed [COORD_BITS-1:0] i_left_b,
    input  logic signed [COORD_BITS-1:0] i_left_c,
    input  logic signed [COORD_BITS-1:0] i_left_d,
    input  logic [3:0]                   i_right_kind,
    input  logic signed [COORD_BITS-1:0] i_right_a,
    input  logic signed [COORD_BITS-1:0] i_right_b,
    input  logic signed [COORD_BITS-1:0] i_right_c,
    input  logic signed [COORD_BITS-1:0] i_right_d,
    output logic                         o_valid,
    output logic                         o_hit,
    output logic                         o_pair_valid
);
    import spc_pkg::*;

    localparam int LATENCY = 8;

    logic                            f_valid, m_valid;
    t_tag                            f_tag, m_tag;
    logic signed [COORD_BITS+1:0]    f_ma [NUM_SLOT];
    logic signed [COORD_BITS+1:0]    f_mb [NUM_SLOT];
    logic signed [2*COORD_BITS+4:0]  m_cr, m_len, m_r2;

    // never hold off a request
    assign busy = 1'b0;

    spc_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start && !busy),
        .i_left_kind  (i_left_kind),
        .i_left_a     (i_left_a),
        .i_left_b     (i_left_b),
        .i_left_c     (i_left_c),
        .i_left_d     (i_left_d),
        .i_right_kind (i_right_kind),
        .i_right_a    (i_right_a),
        .i_right_b    (i_right_b),
        .i_right_c    (i_right_c),
        .i_right_d    (i_right_d),
        .o_valid      (f_valid),
        .o_tag        (f_tag),
        .o_ma         (f_ma),
        .o_mb         (f_mb)
    );

    spc_mult #(.COORD_BITS(COORD_BITS)) u_mult (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_tag   (f_tag),
        .i_ma    (f_ma),
        .i_mb    (f_mb),
        .o_valid (m_valid),
        .o_tag   (m_tag),
        .o_cr    (m_cr),
        .o_len   (m_len),
        .o_r2    (m_r2)
    );

    spc_wide #(.COORD_BITS(COORD_BITS)) u_wide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (m_valid),
        .i_tag        (m_tag),
        .i_cr         (m_cr),
        .i_len        (m_len),
        .i_r2         (m_r2),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_pair_valid (o_pair_valid)
    );

    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, LATENCY))
        else $error("result strobe without a matching request");

endmodule

// File: tb/shape_pair_collision_test_tb.sv
// ----------------------------------------------------------------------------
// shape_pair_collision_test_tb: self-checking bench for the shape pair test
// Drives directed shape pairs and random bursts, predicts hit and pair_valid with exact
// wide integer geometry, and checks every result strobe in request order.
// ----------------------------------------------------------------------------
module shape_pair_collision_test_tb;
    import spc_pkg::*;

    localparam int CB = 16;
    localparam int LATENCY = 8;

    typedef logic signed [127:0] w_t;
    typedef struct {
        logic [3:0] kind;
        longint     a, b, c, d;
    } shape_t;
    typedef struct {
        logic hit;
        logic pair_valid;
    } verdict_t;

    logic i_clk, i_rst_n, start, busy;
    logic [3:0] i_left_kind, i_right_kind;
    logic signed [CB-1:0] i_left_a, i_left_b, i_left_c, i_left_d;
    logic signed [CB-1:0] i_right_a, i_right_b, i_right_c, i_right_d;
    logic o_valid, o_hit, o_pair_valid;

    verdict_t verdict_q[$];
    int errors = 0;

    shape_pair_collision_test #(.COORD_BITS(CB)) DUT (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------
    // geometry predictor
    // ------------------------------------------------------------------
    function automatic w_t wm(longint x, longint y);
        return w_t'(x) * w_t'(y);
    endfunction

    function automatic logic in_box(shape_t r, longint x, longint y);
        return x >= r.a && x <= r.c && y >= r.b && y <= r.d;
    endfunction

    function automatic logic rect_vs_circle(shape_t r, shape_t s);
        longint rad2, dx, dy, hw, hh;
        if (s.c < 0) return 1'b0;
        rad2 = 2 * s.c;
        dx = 2 * s.a - (r.a + r.c);
        dy = 2 * s.b - (r.b + r.d);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        hw = r.c - r.a;
        hh = r.d - r.b;
        if (dx > hw + rad2 || dy > hh + rad2) return 1'b0;
        if (dx <= hw || dy <= hh) return 1'b1;
        return wm(dx - hw, dx - hw) + wm(dy - hh, dy - hh) <= wm(rad2, rad2);
    endfunction

    function automatic logic circle_vs_seg(shape_t s, shape_t l);
        longint fx, fy, dx, dy, gx, gy;
        w_t dot, len, r2, cr;
        if (s.c < 0) return 1'b0;
        r2 = wm(s.c, s.c);
        fx = s.a - l.a;
        fy = s.b - l.b;
        dx = l.c - l.a;
        dy = l.d - l.b;
        dot = wm(fx, dx) + wm(fy, dy);
        len = wm(dx, dx) + wm(dy, dy);
        if (dot <= 0) return wm(fx, fx) + wm(fy, fy) <= r2;
        if (len <= dot) begin
            gx = s.a - l.c;
            gy = s.b - l.d;
            return wm(gx, gx) + wm(gy, gy) <= r2;
        end
        cr = wm(fx, dy) - wm(fy, dx);
        return cr * cr <= r2 * len;
    endfunction

    function automatic logic seg_vs_seg(shape_t p, shape_t q);
        longint dx1, dy1, dx2, dy2, ex, ey;
        w_t det, n1, n2;
        dx1 = p.c - p.a; dy1 = p.d - p.b;
        dx2 = q.c - q.a; dy2 = q.d - q.b;
        ex = q.a - p.a;  ey = q.b - p.b;
        det = wm(dx1, dy2) - wm(dy1, dx2);
        n1 = wm(ex, dy2) - wm(ey, dx2);
        n2 = wm(dx1, ey) - wm(dy1, ex);
        if (det == 0) return 1'b0;
        if (det < 0) begin
            det = -det; n1 = -n1; n2 = -n2;
        end
        return n1 >= 0 && n1 <= det && n2 >= 0 && n2 <= det;
    endfunction

    function automatic logic ordered_hit(shape_t p, shape_t q);
        longint dx, dy;
        dx = p.a - q.a;
        dy = p.b - q.b;
        case ({p.kind, q.kind})
            {KIND_PT, KIND_PT}:     return p.a == q.a && p.b == q.b;
            {KIND_PT, KIND_RECT}:   return in_box(q, p.a, p.b);
            {KIND_PT, KIND_CIRC}:   return q.c >= 0 && wm(dx, dx) + wm(dy, dy) <= wm(q.c, q.c);
            {KIND_RECT, KIND_RECT}: return p.a <= q.c && p.c >= q.a && p.b <= q.d && p.d >= q.b;
            {KIND_RECT, KIND_CIRC}: return rect_vs_circle(p, q);
            {KIND_RECT, KIND_LINE}: return in_box(p, q.a, q.b) || in_box(p, q.c, q.d);
            {KIND_CIRC, KIND_CIRC}: return p.c >= 0 && q.c >= 0 &&
                wm(dx, dx) + wm(dy, dy) <= wm(p.c + q.c, p.c + q.c);
            {KIND_CIRC, KIND_LINE}: return circle_vs_seg(p, q);
            {KIND_LINE, KIND_LINE}: return seg_vs_seg(p, q);
            default:                return 1'b0;
        endcase
    endfunction

    function automatic logic is_kind(logic [3:0] k);
        return k == KIND_PT || k == KIND_RECT || k == KIND_CIRC || k == KIND_LINE;
    endfunction

    function automatic verdict_t predict_collision(shape_t l, shape_t r);
        verdict_t v;
        v.pair_valid = is_kind(l.kind) && is_kind(r.kind);
        v.hit = 1'b0;
        if (v.pair_valid)
            v.hit = (l.kind <= r.kind) ? ordered_hit(l, r) : ordered_hit(r, l);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // request driver: hold the pair until accepted
    // ------------------------------------------------------------------
    task automatic send_pair(shape_t l, shape_t r);
        start = 1'b1;
        i_left_kind = l.kind;
        i_left_a = l.a[CB-1:0]; i_left_b = l.b[CB-1:0];
        i_left_c = l.c[CB-1:0]; i_left_d = l.d[CB-1:0];
        i_right_kind = r.kind;
        i_right_a = r.a[CB-1:0]; i_right_b = r.b[CB-1:0];
        i_right_c = r.c[CB-1:0]; i_right_d = r.d[CB-1:0];
        l.a = longint'(i_left_a); l.b = longint'(i_left_b);
        l.c = longint'(i_left_c); l.d = longint'(i_left_d);
        r.a = longint'(i_right_a); r.b = longint'(i_right_b);
        r.c = longint'(i_right_c); r.d = longint'(i_right_d);
        forever begin
            @(posedge i_clk);
            if (!busy) break;
            @(negedge i_clk);
        end
        verdict_q.push_back(predict_collision(l, r));
        @(negedge i_clk);
    endtask

    // drop start for a random gap, or keep streaming
    task automatic idle_gap();
        int n;
        if ($urandom_range(0, 3) != 0) return;
        n = $urandom_range(1, 6);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    function automatic shape_t mk(logic [3:0] k, longint a, longint b, longint c, longint d);
        shape_t s;
        s.kind = k; s.a = a; s.b = b; s.c = c; s.d = d;
        return s;
    endfunction

    function automatic longint rnd_coord(int span);
        if (span == 0) return longint'($signed(16'($urandom)));
        return longint'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic shape_t rnd_shape(int span);
        shape_t s;
        longint t;
        case ($urandom_range(0, 9))
            0, 1:    s.kind = KIND_PT;
            2, 3:    s.kind = KIND_RECT;
            4, 5:    s.kind = KIND_CIRC;
            6, 7, 8: s.kind = KIND_LINE;
            default: s.kind = 4'($urandom);
        endcase
        s.a = rnd_coord(span); s.b = rnd_coord(span);
        s.c = rnd_coord(span); s.d = rnd_coord(span);
        // mostly well-formed rectangles and non-negative radii
        if (s.kind == KIND_RECT && $urandom_range(0, 7) != 0) begin
            if (s.c < s.a) begin t = s.a; s.a = s.c; s.c = t; end
            if (s.d < s.b) begin t = s.b; s.b = s.d; s.d = t; end
        end
        if (s.kind == KIND_CIRC && s.c < 0 && $urandom_range(0, 7) != 0) s.c = -s.c;
        if (span != 0 && $urandom_range(0, 15) == 0) s.c = s.a;
        return s;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        send_pair(mk(KIND_PT, -32768, 32767, 0, 0), mk(KIND_PT, -32768, 32767, -1, -1));
        send_pair(mk(KIND_PT, 5, 5, 0, 0), mk(KIND_PT, 5, 6, 0, 0));
        send_pair(mk(KIND_RECT, -32768, -32768, 32767, 32767), mk(KIND_PT, 32767, -32768, 0, 0));
        send_pair(mk(KIND_PT, 0, 0, 0, 0), mk(KIND_CIRC, 32767, 32767, 32767, 0));
        send_pair(mk(KIND_CIRC, -32768, -32768, 32767, 0), mk(KIND_CIRC, 32767, 32767, 32767, 0));
        send_pair(mk(KIND_CIRC, 0, 0, -1, 0), mk(KIND_PT, 0, 0, 0, 0));
        send_pair(mk(KIND_CIRC, 0, 0, -32768, 0), mk(KIND_CIRC, 0, 0, 10, 0));
        send_pair(mk(KIND_RECT, 10, 10, 0, 0), mk(KIND_PT, 5, 5, 0, 0));
        send_pair(mk(KIND_RECT, 0, 0, 10, 10), mk(KIND_RECT, 10, 10, 20, 20));
        send_pair(mk(KIND_RECT, 0, 0, 10, 10), mk(KIND_CIRC, 13, 14, 5, 0));
        send_pair(mk(KIND_CIRC, 13, 14, 4, 0), mk(KIND_RECT, 0, 0, 10, 10));
        send_pair(mk(KIND_RECT, 0, 0, 10, 10), mk(KIND_CIRC, 5, 5, -2, 0));
        send_pair(mk(KIND_LINE, -5, 5, 5, 20), mk(KIND_RECT, 0, 0, 10, 10));
        send_pair(mk(KIND_PT, 0, 0, 0, 0), mk(KIND_LINE, -5, 0, 5, 0));
        send_pair(mk(KIND_LINE, -10, 0, 10, 0), mk(KIND_CIRC, 0, 3, 3, 0));
        send_pair(mk(KIND_CIRC, 12, 0, 2, 0), mk(KIND_LINE, -10, 0, 10, 0));
        send_pair(mk(KIND_CIRC, 4, 4, 1, 0), mk(KIND_LINE, 4, 5, 4, 5));
        send_pair(mk(KIND_LINE, -32768, -32768, 32767, 32767),
                  mk(KIND_LINE, -32768, 32767, 32767, -32768));
        send_pair(mk(KIND_LINE, 0, 0, 10, 0), mk(KIND_LINE, 10, -5, 10, 5));
        send_pair(mk(KIND_LINE, 0, 0, 10, 0), mk(KIND_LINE, 5, 0, 15, 0));
        send_pair(mk(KIND_LINE, 3, 3, 3, 3), mk(KIND_LINE, 0, 0, 6, 6));
        send_pair(mk(4'd3, 0, 0, 0, 0), mk(KIND_PT, 0, 0, 0, 0));
        send_pair(mk(4'd0, 0, 0, 0, 0), mk(4'd15, 0, 0, 0, 0));
        send_pair(mk(KIND_RECT, 0, 0, 0, 0), mk(4'd12, -1, -1, -1, -1));
        start = 1'b0;
    endtask

    task automatic test_random_near(int count);
        for (int i = 0; i < count; i++) begin
            send_pair(rnd_shape(40), rnd_shape(40));
            idle_gap();
        end
        start = 1'b0;
    endtask

    task automatic test_random_wide(int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 1)) send_pair(rnd_shape(0), rnd_shape(0));
            else send_pair(rnd_shape(3000), rnd_shape(3000));
            idle_gap();
        end
        start = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        verdict_t v;
        if (i_rst_n && o_valid) begin
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected result hit=%b pair_valid=%b",
                         $time, o_hit, o_pair_valid);
                errors++;
            end else begin
                v = verdict_q.pop_front();
                if (o_hit !== v.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, v.hit, o_hit);
                    errors++;
                end
                if (o_pair_valid !== v.pair_valid) begin
                    $display("%0t: pair_valid expected %b actual %b",
                             $time, v.pair_valid, o_pair_valid);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_left_kind = '0; i_left_a = '0; i_left_b = '0; i_left_c = '0; i_left_d = '0;
        i_right_kind = '0; i_right_a = '0; i_right_b = '0; i_right_c = '0; i_right_d = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random_near(1200);
        test_random_wide(700);
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (errors == 0 && verdict_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: shape_pair_collision_test.f
rtl/spc_pkg.sv
rtl/spc_front.sv
rtl/spc_mult.sv
rtl/spc_wide.sv
rtl/shape_pair_collision_test.sv
tb/shape_pair_collision_test_tb.sv
